/* hw/rtl/coe_pkg.sv */
`default_nettype none

package coe_pkg;

    localparam int SUM_W    = 24;
    localparam int CNT_W    = 7;
    localparam int OFFSET_W = 16;
    localparam int CHAN_W   = 9;
    localparam int TIME_W   = 48;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam int CHAN_LSB   = 0;
    localparam int TIME_LSB   = CHAN_LSB + CHAN_W;
    localparam int SAMPLE_LSB = TIME_LSB + TIME_W;

    localparam logic [CFG_W-1:0] AP_SETTLE_RESET  = CFG_W'(30000 * 5);
    localparam logic [CFG_W-1:0] LFP_SETTLE_RESET = CFG_W'(2500 * 5);

    localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

    localparam logic signed [OFFSET_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OFFSET_W-1:0] OUT_MIN = 16'sh8000;

    // register select: word address bit of paddr
    localparam logic REG_AP_SETTLE  = 1'b0;
    localparam logic REG_LFP_SETTLE = 1'b1;

    localparam logic BAND_LFP = 1'b0;
    localparam logic BAND_AP  = 1'b1;

    typedef struct packed {
        logic                    ready;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/coe_ram.sv */
`default_nettype none

module coe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/channel_offset_estimator.sv */
`default_nettype none

// Per-channel DC offset estimator for two bands (LFP, AP). One sample request
// is taken per cycle unless back-pressure from m_tready stalls the pipeline or
// the store is being cleared; its result leaves through a pipeline of memory read,
// read-modify-write of the sum store (with a one-deep write bypass),
// magnitude/rounding, reciprocal multiply and saturation. The sum store is a
// single-port-write, registered-read RAM of 2*CHANNELS entries; after reset it
// is cleared one entry per cycle, and s_tready stays low until every entry is cleared.
// Settle thresholds are written over APB at any time; they must be changed only while no request is in flight.
module channel_offset_estimator #(
    parameter int CHANNELS    = 384,
    parameter int AVG_FRAMES  = 99,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                            aclk,
    input  wire                            aresetn,

    input  wire                            s_tvalid,
    output logic                           s_tready,
    // [8:0] channel, [56:9] frame_time, [72:57] sample, [79:73] zero
    input  wire [coe_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] band
    input  wire                            s_tuser,

    output logic                           m_tvalid,
    input  wire                            m_tready,
    // [15:0] offset
    output logic [coe_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] ready_res
    output logic                           m_tuser,

    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [coe_pkg::PADDR_W-1:0]     paddr,
    input  wire [coe_pkg::CFG_W-1:0]       pwdata,
    output logic [coe_pkg::CFG_W-1:0]      prdata,
    output logic                           pready
);

    localparam int DEPTH   = 2 * CHANNELS;
    localparam int AW      = $clog2(DEPTH);
    localparam int EW      = coe_pkg::SUM_W + 1;
    localparam int SHIFT   = coe_pkg::SUM_W - SAMPLE_BITS;
    localparam int HALF    = AVG_FRAMES / 2;
    localparam int RSHIFT  = coe_pkg::SUM_W + 7;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << RSHIFT) + 64'(AVG_FRAMES) - 64'd1)
                                         / 64'(AVG_FRAMES);
    localparam int RW      = 32;
    localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];
    localparam int PW      = coe_pkg::SUM_W + RW;
    localparam int QW      = PW - RSHIFT;

    // ---------------- configuration ----------------
    logic [coe_pkg::CFG_W-1:0] ap_settle_reg;
    logic [coe_pkg::CFG_W-1:0] lfp_settle_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ap_settle_reg  <= coe_pkg::AP_SETTLE_RESET;
            lfp_settle_reg <= coe_pkg::LFP_SETTLE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                coe_pkg::REG_AP_SETTLE:  ap_settle_reg  <= pwdata;
                coe_pkg::REG_LFP_SETTLE: lfp_settle_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            coe_pkg::REG_AP_SETTLE:  prdata = ap_settle_reg;
            coe_pkg::REG_LFP_SETTLE: prdata = lfp_settle_reg;
            default:                 prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic rdy_out, rdy4, rdy3, rdy2, rdy1;
    logic clr_active_reg;
    logic in_accept;

    assign rdy_out   = !out_valid_reg || m_tready;
    assign rdy4      = !s4_valid_reg || rdy_out;
    assign rdy3      = !s3_valid_reg || rdy4;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign s_tready  = rdy1 && !clr_active_reg;
    assign in_accept = s_tvalid && s_tready;

    // ---------------- input decode ----------------
    logic [coe_pkg::CHAN_W-1:0]   in_chan;
    logic [coe_pkg::TIME_W-1:0]   in_time;
    logic [coe_pkg::SAMPLE_W-1:0] in_sample;
    logic [coe_pkg::SUM_W-1:0]    raw_shifted;
    logic signed [coe_pkg::SUM_W-1:0] in_smp;
    logic                         in_range;
    logic                         in_last;
    logic                         in_settled;
    logic                         in_qual;
    logic [AW-1:0]                in_idx;
    logic [coe_pkg::CNT_W-1:0]    cnt_sel;
    logic                         in_add;

    assign in_chan   = s_tdata[coe_pkg::CHAN_LSB +: coe_pkg::CHAN_W];
    assign in_time   = s_tdata[coe_pkg::TIME_LSB +: coe_pkg::TIME_W];
    assign in_sample = s_tdata[coe_pkg::SAMPLE_LSB +: coe_pkg::SAMPLE_W];

    assign raw_shifted = coe_pkg::SUM_W'(in_sample) << SHIFT;
    assign in_smp      = $signed(raw_shifted) >>> SHIFT;

    assign in_range = 32'(in_chan) < 32'(CHANNELS);
    assign in_last  = 32'(in_chan) == 32'(CHANNELS - 1);
    assign in_idx   = (s_tuser == coe_pkg::BAND_AP) ? AW'(in_chan) + AW'(CHANNELS)
                                                    : AW'(in_chan);

    logic [coe_pkg::CNT_W-1:0] ap_cnt_reg, lfp_cnt_reg;

    always_comb begin
        if (s_tuser == coe_pkg::BAND_AP) begin
            in_settled = in_time > coe_pkg::TIME_W'(ap_settle_reg);
            cnt_sel    = ap_cnt_reg;
        end else begin
            in_settled = in_time > coe_pkg::TIME_W'(lfp_settle_reg);
            cnt_sel    = lfp_cnt_reg;
        end
    end

    assign in_qual = in_range && in_settled;
    assign in_add  = cnt_sel < coe_pkg::CNT_W'(AVG_FRAMES);

    logic cnt_bump;
    assign cnt_bump = in_accept && in_qual && in_last
                      && (cnt_sel <= coe_pkg::CNT_W'(AVG_FRAMES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ap_cnt_reg  <= '0;
            lfp_cnt_reg <= '0;
        end else if (cnt_bump) begin
            if (s_tuser == coe_pkg::BAND_AP) begin
                ap_cnt_reg <= ap_cnt_reg + 1'b1;
            end else begin
                lfp_cnt_reg <= lfp_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- clearing pass ----------------
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: read-modify-write ----------------
    logic                         s1_range_reg, s1_qual_reg, s1_add_reg;
    logic [AW-1:0]                s1_idx_reg;
    logic signed [coe_pkg::SUM_W-1:0] s1_smp_reg;
    logic                         fwd_hit_reg;
    coe_pkg::entry_t              fwd_data_reg;
    logic [EW-1:0]                ram_rdata;
    coe_pkg::entry_t              s1_cur, s1_new;
    logic signed [coe_pkg::SUM_W:0] s1_wide;
    logic                         s1_we;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [EW-1:0]                ram_wdata;

    always_comb begin
        s1_cur  = fwd_hit_reg ? fwd_data_reg : coe_pkg::entry_t'(ram_rdata);
        s1_new  = s1_cur;
        s1_wide = {s1_cur.sum[coe_pkg::SUM_W-1], s1_cur.sum}
                  + {s1_smp_reg[coe_pkg::SUM_W-1], s1_smp_reg};
        if (s1_qual_reg) begin
            if (s1_add_reg) begin
                if (s1_wide[coe_pkg::SUM_W] != s1_wide[coe_pkg::SUM_W-1]) begin
                    s1_new.sum = s1_wide[coe_pkg::SUM_W] ? coe_pkg::SUM_MIN
                                                         : coe_pkg::SUM_MAX;
                end else begin
                    s1_new.sum = s1_wide[coe_pkg::SUM_W-1:0];
                end
            end else begin
                s1_new.ready = 1'b1;
            end
        end
    end

    assign s1_we     = s1_valid_reg && s1_qual_reg && rdy2;
    assign ram_we    = clr_active_reg || s1_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_idx_reg;
    assign ram_wdata = clr_active_reg ? '0 : EW'(s1_new);

    coe_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_tready),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
            fwd_hit_reg  <= s1_we && (s1_idx_reg == in_idx);
        end else if (rdy2) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_range_reg <= in_range;
            s1_qual_reg  <= in_qual;
            s1_add_reg   <= in_add;
            s1_idx_reg   <= in_idx;
            s1_smp_reg   <= in_smp;
            fwd_data_reg <= s1_new;
        end
    end

    // ---------------- stage 2: magnitude and rounding bias ----------------
    logic                             s2_ready_reg;
    logic signed [coe_pkg::SUM_W-1:0] s2_sum_reg;
    logic                             s2_neg;
    logic [coe_pkg::SUM_W-1:0]        s2_mag;

    assign s2_neg = s2_sum_reg[coe_pkg::SUM_W-1];
    assign s2_mag = (s2_neg ? (~s2_sum_reg + 1'b1) : s2_sum_reg)
                    + coe_pkg::SUM_W'(HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_ready_reg <= s1_range_reg && s1_new.ready;
            s2_sum_reg   <= s1_new.sum;
        end
    end

    // ---------------- stage 3: reciprocal multiply ----------------
    logic                      s3_ready_reg, s3_neg_reg;
    logic [coe_pkg::SUM_W-1:0] s3_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (rdy3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_ready_reg <= s2_ready_reg;
            s3_neg_reg   <= s2_neg;
            s3_mag_reg   <= s2_mag;
        end
    end

    // ---------------- stage 4: quotient and saturation ----------------
    logic          s4_ready_reg, s4_neg_reg;
    logic [PW-1:0] s4_prod_reg;
    logic [QW-1:0] s4_q;
    logic signed [coe_pkg::OFFSET_W-1:0] s4_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (rdy4) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_ready_reg <= s3_ready_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_prod_reg  <= PW'(s3_mag_reg) * PW'(RECIP);
        end
    end

    assign s4_q = s4_prod_reg[PW-1:RSHIFT];

    always_comb begin
        if (!s4_ready_reg) begin
            s4_offset = '0;
        end else if (s4_neg_reg) begin
            if (s4_q > QW'(32768)) begin
                s4_offset = coe_pkg::OUT_MIN;
            end else begin
                s4_offset = coe_pkg::OFFSET_W'(~s4_q + 1'b1);
            end
        end else begin
            if (s4_q > QW'(coe_pkg::OUT_MAX)) begin
                s4_offset = coe_pkg::OUT_MAX;
            end else begin
                s4_offset = coe_pkg::OFFSET_W'(s4_q);
            end
        end
    end

    // ---------------- result register ----------------
    logic [coe_pkg::OFFSET_W-1:0] out_offset_reg;
    logic                         out_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            out_offset_reg <= s4_offset;
            out_ready_reg  <= s4_ready_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_ready_reg;

    // ---------------- assertions ----------------
    a_no_work_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s1_valid_reg)
        else $error("request in flight during clearing pass");

    a_ap_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ap_cnt_reg <= coe_pkg::CNT_W'(AVG_FRAMES + 1))
        else $error("AP frame counter past frozen value");

    a_lfp_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lfp_cnt_reg <= coe_pkg::CNT_W'(AVG_FRAMES + 1))
        else $error("LFP frame counter past frozen value");

    a_bypass_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fwd_hit_reg) |-> $past(s1_we))
        else $error("bypass taken without a preceding write");

endmodule

`default_nettype wire
